### hw/rtl/iydi_pkg.sv
// ----------------------------------------------------------------------------
// iydi_pkg
// shared constants, codes and types of the yaw and distance integrator
// ----------------------------------------------------------------------------
package iydi_pkg;

    // calibration run length and the widths that follow from it
    localparam int CAL_SAMPLES = 100;
    localparam int CAL_CNT_W   = $clog2(CAL_SAMPLES + 1);
    localparam int SUM_W       = 16 + $clog2(CAL_SAMPLES + 1);

    // serial unit widths
    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = 64;
    localparam int DVD_W   = 68;
    localparam int DVS_W   = 17;
    localparam int DIV_CNT_W = 7;

    // arithmetic constants
    localparam logic [DVS_W-1:0] YAW_DIVISOR  = 17'd131000;
    localparam logic [DVS_W-1:0] DIST_DIVISOR = 17'd15625;
    localparam logic [15:0]      YAW_ROUND    = 16'd65500;
    localparam logic [15:0]      DEADBAND_RST = 16'd1311;

    // command codes
    localparam logic [1:0] CMD_CAL       = 2'd0;
    localparam logic [1:0] CMD_MOTION    = 2'd1;
    localparam logic [1:0] CMD_RESET_YAW = 2'd2;
    localparam logic [1:0] CMD_RESET_VEL = 2'd3;

    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic signed [39:0]      vel_t;

endpackage

### hw/rtl/iydi_serial_mul.sv
// ----------------------------------------------------------------------------
// iydi_serial_mul
// shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module iydi_serial_mul (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [iydi_pkg::MUL_A_W-1:0]   a,
    input  logic [iydi_pkg::MUL_B_W-1:0]   b,
    output logic                           done,
    output logic [iydi_pkg::MUL_P_W-1:0]   prod
);

    logic                          busy_reg, busy_next;
    logic [iydi_pkg::MUL_P_W-1:0]  a_reg, a_next;
    logic [iydi_pkg::MUL_B_W-1:0]  b_reg, b_next;
    logic [iydi_pkg::MUL_P_W-1:0]  acc_reg, acc_next;

    assign done = busy_reg && (b_reg == '0);
    assign prod = acc_reg;

    always_comb begin
        busy_next = busy_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            a_next    = iydi_pkg::MUL_P_W'(a);
            b_next    = b;
            acc_next  = '0;
        end else if (busy_reg) begin
            if (b_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                if (b_reg[0]) begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = {a_reg[iydi_pkg::MUL_P_W-2:0], 1'b0};
                b_next = {1'b0, b_reg[iydi_pkg::MUL_B_W-1:1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

endmodule

### hw/rtl/iydi_serial_div.sv
// ----------------------------------------------------------------------------
// iydi_serial_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module iydi_serial_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [iydi_pkg::DVD_W-1:0]    dividend,
    input  logic [iydi_pkg::DVS_W-1:0]    divisor,
    output logic                          done,
    output logic [iydi_pkg::DVD_W-1:0]    quotient
);

    logic                            busy_reg, busy_next;
    logic [iydi_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [iydi_pkg::DVD_W-1:0]      dvd_reg, dvd_next;
    logic [iydi_pkg::DVS_W-1:0]      rem_reg, rem_next;
    logic [iydi_pkg::DVS_W-1:0]      dvs_reg, dvs_next;
    logic [iydi_pkg::DVS_W:0]        rem_shift;
    logic                            ge;

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = dvd_reg;

    // dividend bits leave at the top, quotient bits enter at the bottom
    assign rem_shift = {rem_reg, dvd_reg[iydi_pkg::DVD_W-1]};
    assign ge        = rem_shift >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = iydi_pkg::DIV_CNT_W'(iydi_pkg::DVD_W);
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                rem_next = ge ? iydi_pkg::DVS_W'(rem_shift - {1'b0, dvs_reg})
                              : iydi_pkg::DVS_W'(rem_shift);
                dvd_next = {dvd_reg[iydi_pkg::DVD_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

### hw/rtl/iydi_serial_sqrt.sv
// ----------------------------------------------------------------------------
// iydi_serial_sqrt
// bit-pair integer square root of a 64-bit value, 32 steps
// ----------------------------------------------------------------------------
module iydi_serial_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] x,
    output logic        done,
    output logic [31:0] root
);

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] root_reg, root_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] trial;

    assign done  = busy_reg && (cnt_reg == '0);
    assign root  = root_reg[31:0];
    assign trial = root_reg + bit_reg;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            x_next    = x;
            root_next = '0;
            bit_next  = 64'h4000_0000_0000_0000;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                if (x_reg >= trial) begin
                    x_next    = x_reg - trial;
                    root_next = {1'b0, root_reg[63:1]} + bit_reg;
                end else begin
                    root_next = {1'b0, root_reg[63:1]};
                end
                bit_next = {2'b00, bit_reg[63:2]};
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        x_reg    <= x_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

endmodule

### hw/rtl/imu_yaw_and_distance_integrator_unit.sv
// ----------------------------------------------------------------------------
// imu_yaw_and_distance_integrator_unit
// gyro bias calibration and dead reckoning of yaw and path length
// ----------------------------------------------------------------------------
// usage
//   input items arrive on the s_ stream: s_tuser carries the command, s_tdata
//   the raw gyro z, accel x, accel y and the step in milliseconds
//   every item returns exactly one result item on the m_ stream: yaw in
//   Q16.16 degrees, path length in Q16.16 and the calibrated flag
//   the yaw deadband register is written through cfg_wr_en / cfg_wr_data
// timing
//   one item is worked on at a time; s_tready is high only while idle
//   reset and calibration items pass from idle to ST_DONE and then into the
//   output register; the last item of a calibration run first makes three
//   68-step divider passes
//   motion items run the shift-add multiplier passes, the 32-step root and
//   two 68-step divider passes
// reset and stall
//   aresetn zeroes sequencer and accumulated state, sets the deadband to 1311
//   a finished result sits in the output register; the next item may be
//   accepted meanwhile, and its result waits until m_tready takes the first
// ----------------------------------------------------------------------------
module imu_yaw_and_distance_integrator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: yaw_deadband_q16
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // gyro_z, accel_x, accel_y, elapsed_ms
    input  logic [1:0]  s_tuser,   // cmd
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // yaw_deg_q16, distance_q16, calibrated, zero pad
);

    // sequencer codes
    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_CDIV_GO   = 5'd1;
    localparam logic [4:0] ST_CDIV_WAIT = 5'd2;
    localparam logic [4:0] ST_YMUL_GO   = 5'd3;
    localparam logic [4:0] ST_YMUL_WAIT = 5'd4;
    localparam logic [4:0] ST_YDIV_GO   = 5'd5;
    localparam logic [4:0] ST_YDIV_WAIT = 5'd6;
    localparam logic [4:0] ST_VMUL_GO   = 5'd7;
    localparam logic [4:0] ST_VMUL_WAIT = 5'd8;
    localparam logic [4:0] ST_ABS       = 5'd9;
    localparam logic [4:0] ST_NORM      = 5'd10;
    localparam logic [4:0] ST_SQ_GO     = 5'd11;
    localparam logic [4:0] ST_SQ_WAIT   = 5'd12;
    localparam logic [4:0] ST_SQRT_GO   = 5'd13;
    localparam logic [4:0] ST_SQRT_WAIT = 5'd14;
    localparam logic [4:0] ST_DMUL_GO   = 5'd15;
    localparam logic [4:0] ST_DMUL_WAIT = 5'd16;
    localparam logic [4:0] ST_DDIV_GO   = 5'd17;
    localparam logic [4:0] ST_DDIV_WAIT = 5'd18;
    localparam logic [4:0] ST_DONE      = 5'd19;

    localparam int CW = iydi_pkg::CAL_CNT_W;
    localparam int SW = iydi_pkg::SUM_W;

    logic [4:0]               state_reg, state_next;
    logic [1:0]               sel_reg, sel_next;
    logic [15:0]              deadband_reg, deadband_next;
    logic [CW-1:0]            cal_count_reg, cal_count_next;
    iydi_pkg::sum_t           gsum_reg, gsum_next;
    iydi_pkg::sum_t           xsum_reg, xsum_next;
    iydi_pkg::sum_t           ysum_reg, ysum_next;
    logic signed [15:0]       gbias_reg, gbias_next;
    logic signed [15:0]       xbias_reg, xbias_next;
    logic signed [15:0]       ybias_reg, ybias_next;
    logic signed [31:0]       yaw_reg, yaw_next;
    iydi_pkg::vel_t           velx_reg, velx_next;
    iydi_pkg::vel_t           vely_reg, vely_next;
    iydi_pkg::vel_t           pvx_reg, pvx_next;
    iydi_pkg::vel_t           pvy_reg, pvy_next;
    logic [31:0]              dist_reg, dist_next;
    logic                     valid_reg, valid_next;
    logic signed [15:0]       ax_reg, ax_next;
    logic signed [15:0]       ay_reg, ay_next;
    logic [15:0]              ms_reg, ms_next;
    logic signed [16:0]       dgz_reg, dgz_next;
    logic [40:0]              ux_reg, ux_next;
    logic [40:0]              uy_reg, uy_next;
    logic [3:0]               k_reg, k_next;
    logic [63:0]              sumsq_reg, sumsq_next;
    logic                     mvalid_reg, mvalid_next;
    logic [71:0]              mdata_reg, mdata_next;

    // serial units; the multiplier and divider are shared between steps
    logic                           mul_start, mul_done;
    logic [iydi_pkg::MUL_A_W-1:0]   mul_a;
    logic [iydi_pkg::MUL_B_W-1:0]   mul_b;
    logic [iydi_pkg::MUL_P_W-1:0]   mul_prod;
    logic                           div_start, div_done;
    logic [iydi_pkg::DVD_W-1:0]     div_dividend, div_q;
    logic [iydi_pkg::DVS_W-1:0]     div_divisor;
    logic                           sqrt_start, sqrt_done;
    logic [31:0]                    sqrt_root;

    // fields of the input item
    logic signed [15:0] in_gz, in_ax, in_ay;
    logic [15:0]        in_ms;
    logic               in_acc;

    // working values
    iydi_pkg::sum_t     sum_sel;
    logic [SW-1:0]      sum_abs;
    logic signed [15:0] bias_q;
    logic [CW-1:0]      cnt_inc;
    logic [16:0]        dgz_abs;
    logic [32:0]        yaw_mag;
    logic signed [33:0] yaw_sum;
    logic signed [16:0] acc_diff;
    logic [16:0]        acc_abs;
    logic signed [40:0] vel_term, vel_sum, vel_old;
    iydi_pkg::vel_t     vel_sat;
    logic signed [40:0] sx, sy;
    logic [40:0]        m_max;
    logic [31:0]        dist_inc;
    logic [32:0]        dist_tot;

    assign in_gz  = s_tdata[15:0];
    assign in_ax  = s_tdata[31:16];
    assign in_ay  = s_tdata[47:32];
    assign in_ms  = s_tdata[63:48];
    assign in_acc = s_tvalid && s_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    // operand selection for the serial units
    assign dgz_abs  = dgz_reg[16] ? 17'(-dgz_reg) : 17'(dgz_reg);
    assign acc_diff = (sel_reg[0]) ? (17'(ay_reg) - 17'(ybias_reg))
                                   : (17'(ax_reg) - 17'(xbias_reg));
    assign acc_abs  = acc_diff[16] ? 17'(-acc_diff) : 17'(acc_diff);

    always_comb begin
        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = iydi_pkg::MUL_B_W'(ms_reg);
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = iydi_pkg::DVS_W'(iydi_pkg::CAL_SAMPLES);
        sqrt_start   = 1'b0;
        unique case (state_reg)
            ST_CDIV_GO: begin
                div_start    = 1'b1;
                div_dividend = iydi_pkg::DVD_W'(sum_abs);
            end
            ST_YMUL_GO: begin
                mul_start = 1'b1;
                mul_a     = iydi_pkg::MUL_A_W'(dgz_abs);
            end
            ST_YDIV_GO: begin
                // |d| * ms * 65536 + rounding, over 131000
                div_start    = 1'b1;
                div_dividend = iydi_pkg::DVD_W'({mul_prod[31:0], 16'h0000})
                             + iydi_pkg::DVD_W'(iydi_pkg::YAW_ROUND);
                div_divisor  = iydi_pkg::YAW_DIVISOR;
            end
            ST_VMUL_GO: begin
                mul_start = 1'b1;
                mul_a     = iydi_pkg::MUL_A_W'(acc_abs);
            end
            ST_SQ_GO: begin
                mul_start = 1'b1;
                mul_a     = sel_reg[0] ? iydi_pkg::MUL_A_W'(uy_reg[30:0])
                                       : iydi_pkg::MUL_A_W'(ux_reg[30:0]);
                mul_b     = sel_reg[0] ? iydi_pkg::MUL_B_W'(uy_reg[30:0])
                                       : iydi_pkg::MUL_B_W'(ux_reg[30:0]);
            end
            ST_SQRT_GO: begin
                sqrt_start = 1'b1;
            end
            ST_DMUL_GO: begin
                mul_start = 1'b1;
                mul_a     = iydi_pkg::MUL_A_W'(sqrt_root) << k_reg;
            end
            ST_DDIV_GO: begin
                // mag * ms * 512 / 15625 equals mag * ms * 65536 / 2000000
                div_start    = 1'b1;
                div_dividend = iydi_pkg::DVD_W'(mul_prod) << 9;
                div_divisor  = iydi_pkg::DIST_DIVISOR;
            end
            default: begin
            end
        endcase
    end

    // calibration helpers
    always_comb begin
        unique case (sel_reg)
            2'd0:    sum_sel = gsum_reg;
            2'd1:    sum_sel = xsum_reg;
            default: sum_sel = ysum_reg;
        endcase
    end
    assign sum_abs = sum_sel[SW-1] ? SW'(-sum_sel) : SW'(sum_sel);
    assign bias_q  = sum_sel[SW-1] ? 16'(-div_q[15:0]) : 16'(div_q[15:0]);
    assign cnt_inc = cal_count_reg + 1'b1;

    // yaw step, saturating add
    assign yaw_mag = div_q[32:0];
    assign yaw_sum = (!dgz_reg[16] && (dgz_reg != '0))
                   ? (34'(yaw_reg) - 34'(signed'({1'b0, yaw_mag})))
                   : (34'(yaw_reg) + 34'(signed'({1'b0, yaw_mag})));

    // velocity step, saturating at 40 bits
    assign vel_old  = sel_reg[0] ? 41'(vely_reg) : 41'(velx_reg);
    assign vel_term = acc_diff[16] ? -41'(signed'({1'b0, mul_prod[31:0]}))
                                   : 41'(signed'({1'b0, mul_prod[31:0]}));
    assign vel_sum  = vel_old + vel_term;
    always_comb begin
        if (vel_sum[40] != vel_sum[39]) begin
            vel_sat = vel_sum[40] ? {1'b1, {39{1'b0}}} : {1'b0, {39{1'b1}}};
        end else begin
            vel_sat = vel_sum[39:0];
        end
    end

    // twice the average velocity per axis
    assign sx    = 41'(velx_reg) + 41'(pvx_reg);
    assign sy    = 41'(vely_reg) + 41'(pvy_reg);
    assign m_max = (ux_reg > uy_reg) ? ux_reg : uy_reg;

    assign dist_inc = (div_q[iydi_pkg::DVD_W-1:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
    assign dist_tot = 33'(dist_inc) + 33'(dist_reg);

    always_comb begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        deadband_next  = cfg_wr_en ? cfg_wr_data : deadband_reg;
        cal_count_next = cal_count_reg;
        gsum_next      = gsum_reg;
        xsum_next      = xsum_reg;
        ysum_next      = ysum_reg;
        gbias_next     = gbias_reg;
        xbias_next     = xbias_reg;
        ybias_next     = ybias_reg;
        yaw_next       = yaw_reg;
        velx_next      = velx_reg;
        vely_next      = vely_reg;
        pvx_next       = pvx_reg;
        pvy_next       = pvy_reg;
        dist_next      = dist_reg;
        valid_next     = valid_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        ms_next        = ms_reg;
        dgz_next       = dgz_reg;
        ux_next        = ux_reg;
        uy_next        = uy_reg;
        k_next         = k_reg;
        sumsq_next     = sumsq_reg;
        mvalid_next    = (mvalid_reg && !m_tready) ? 1'b1 : 1'b0;
        mdata_next     = mdata_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (s_tuser)
                        iydi_pkg::CMD_CAL: begin
                            // a new run starts from cleared sums
                            if (cal_count_reg == '0) begin
                                gsum_next = SW'(in_gz);
                                xsum_next = SW'(in_ax);
                                ysum_next = SW'(in_ay);
                            end else begin
                                gsum_next = gsum_reg + SW'(in_gz);
                                xsum_next = xsum_reg + SW'(in_ax);
                                ysum_next = ysum_reg + SW'(in_ay);
                            end
                            if (cnt_inc >= CW'(iydi_pkg::CAL_SAMPLES)) begin
                                cal_count_next = '0;
                                sel_next       = 2'd0;
                                state_next     = ST_CDIV_GO;
                            end else begin
                                cal_count_next = cnt_inc;
                                state_next     = ST_DONE;
                            end
                        end
                        iydi_pkg::CMD_MOTION: begin
                            ax_next    = in_ax;
                            ay_next    = in_ay;
                            ms_next    = in_ms;
                            dgz_next   = 17'(in_gz) - 17'(gbias_reg);
                            state_next = ST_YMUL_GO;
                        end
                        iydi_pkg::CMD_RESET_YAW: begin
                            yaw_next   = '0;
                            state_next = ST_DONE;
                        end
                        iydi_pkg::CMD_RESET_VEL: begin
                            velx_next  = '0;
                            vely_next  = '0;
                            state_next = ST_DONE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CDIV_GO: begin
                state_next = ST_CDIV_WAIT;
            end
            ST_CDIV_WAIT: begin
                if (div_done) begin
                    unique case (sel_reg)
                        2'd0:    gbias_next = bias_q;
                        2'd1:    xbias_next = bias_q;
                        default: ybias_next = bias_q;
                    endcase
                    if (sel_reg == 2'd2) begin
                        valid_next = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        sel_next   = sel_reg + 1'b1;
                        state_next = ST_CDIV_GO;
                    end
                end
            end
            ST_YMUL_GO: begin
                state_next = ST_YMUL_WAIT;
            end
            ST_YMUL_WAIT: begin
                if (mul_done) begin
                    state_next = ST_YDIV_GO;
                end
            end
            ST_YDIV_GO: begin
                state_next = ST_YDIV_WAIT;
            end
            ST_YDIV_WAIT: begin
                if (div_done) begin
                    // steps under the deadband are dropped
                    if ((yaw_mag >= 33'(deadband_reg)) && (yaw_mag != '0)) begin
                        if (yaw_sum > 34'sh0_7FFF_FFFF) begin
                            yaw_next = 32'sh7FFF_FFFF;
                        end else if (yaw_sum < -34'sh0_8000_0000) begin
                            yaw_next = 32'sh8000_0000;
                        end else begin
                            yaw_next = yaw_sum[31:0];
                        end
                    end
                    sel_next   = 2'd0;
                    state_next = ST_VMUL_GO;
                end
            end
            ST_VMUL_GO: begin
                state_next = ST_VMUL_WAIT;
            end
            ST_VMUL_WAIT: begin
                if (mul_done) begin
                    if (sel_reg[0]) begin
                        vely_next  = vel_sat;
                        pvy_next   = vely_reg;
                        state_next = ST_ABS;
                    end else begin
                        velx_next  = vel_sat;
                        pvx_next   = velx_reg;
                        sel_next   = 2'd1;
                        state_next = ST_VMUL_GO;
                    end
                end
            end
            ST_ABS: begin
                ux_next    = sx[40] ? 41'(-sx) : 41'(sx);
                uy_next    = sy[40] ? 41'(-sy) : 41'(sy);
                k_next     = '0;
                state_next = ST_NORM;
            end
            ST_NORM: begin
                // one shift a cycle until the larger axis is below 2^31
                if (m_max[40:31] != '0) begin
                    ux_next = {1'b0, ux_reg[40:1]};
                    uy_next = {1'b0, uy_reg[40:1]};
                    k_next  = k_reg + 1'b1;
                end else begin
                    sel_next   = 2'd0;
                    sumsq_next = '0;
                    state_next = ST_SQ_GO;
                end
            end
            ST_SQ_GO: begin
                state_next = ST_SQ_WAIT;
            end
            ST_SQ_WAIT: begin
                if (mul_done) begin
                    sumsq_next = sumsq_reg + mul_prod;
                    if (sel_reg[0]) begin
                        state_next = ST_SQRT_GO;
                    end else begin
                        sel_next   = 2'd1;
                        state_next = ST_SQ_GO;
                    end
                end
            end
            ST_SQRT_GO: begin
                state_next = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (sqrt_done) begin
                    state_next = ST_DMUL_GO;
                end
            end
            ST_DMUL_GO: begin
                state_next = ST_DMUL_WAIT;
            end
            ST_DMUL_WAIT: begin
                if (mul_done) begin
                    state_next = ST_DDIV_GO;
                end
            end
            ST_DDIV_GO: begin
                state_next = ST_DDIV_WAIT;
            end
            ST_DDIV_WAIT: begin
                if (div_done) begin
                    dist_next  = dist_tot[32] ? 32'hFFFF_FFFF : dist_tot[31:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait for the output register to be free
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mdata_next  = {7'b0, valid_reg, dist_reg, yaw_reg};
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sel_reg       <= 2'd0;
            deadband_reg  <= iydi_pkg::DEADBAND_RST;
            cal_count_reg <= '0;
            gsum_reg      <= '0;
            xsum_reg      <= '0;
            ysum_reg      <= '0;
            gbias_reg     <= '0;
            xbias_reg     <= '0;
            ybias_reg     <= '0;
            yaw_reg       <= '0;
            velx_reg      <= '0;
            vely_reg      <= '0;
            dist_reg      <= '0;
            valid_reg     <= 1'b0;
            mvalid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            deadband_reg  <= deadband_next;
            cal_count_reg <= cal_count_next;
            gsum_reg      <= gsum_next;
            xsum_reg      <= xsum_next;
            ysum_reg      <= ysum_next;
            gbias_reg     <= gbias_next;
            xbias_reg     <= xbias_next;
            ybias_reg     <= ybias_next;
            yaw_reg       <= yaw_next;
            velx_reg      <= velx_next;
            vely_reg      <= vely_next;
            dist_reg      <= dist_next;
            valid_reg     <= valid_next;
            mvalid_reg    <= mvalid_next;
        end
        pvx_reg   <= pvx_next;
        pvy_reg   <= pvy_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        ms_reg    <= ms_next;
        dgz_reg   <= dgz_next;
        ux_reg    <= ux_next;
        uy_reg    <= uy_next;
        k_reg     <= k_next;
        sumsq_reg <= sumsq_next;
        mdata_reg <= mdata_next;
    end

    iydi_serial_mul u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mul_start),
        .a        (mul_a),
        .b        (mul_b),
        .done     (mul_done),
        .prod     (mul_prod)
    );

    iydi_serial_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    iydi_serial_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .x        (sumsq_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the yaw and distance integrator: a bit-true
// predictor runs beside the block, results are checked in order
// ----------------------------------------------------------------------------
module tb_top;

    localparam int  CYCLE_LIMIT = 1500000;
    localparam logic signed [39:0] VEL_HI = 40'sh7FFFFFFFFF;
    localparam logic signed [39:0] VEL_LO = -40'sh7FFFFFFFFF - 40'sh1;

    typedef struct packed {
        logic        calibrated;
        logic [31:0] distance;
        logic [31:0] yaw;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    // predictor state
    logic [15:0]        deadband;
    int                 cal_cnt;
    longint             gyro_acc, ax_acc, ay_acc;
    longint             gyro_bias, ax_bias, ay_bias;
    logic signed [31:0] yaw_q;
    longint             vx, vy;
    logic [31:0]        dist_q;
    logic               cal_done;

    result_t pending_results[$];
    int      errors = 0;
    longint  cycles = 0;
    bit      quiet = 1'b0;
    int      stall_left = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    imu_yaw_and_distance_integrator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function automatic longint clamp_vel(longint v);
        if (v > longint'(VEL_HI)) return longint'(VEL_HI);
        if (v < longint'(VEL_LO)) return longint'(VEL_LO);
        return v;
    endfunction

    function automatic longint unsigned int_root(longint unsigned x);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (x >= root + bitv) begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // dead reckoning step for one motion item
    task automatic integrate_motion(longint gz, longint ax, longint ay, longint ms);
        longint d, s, px, py;
        longint unsigned mag, ux, uy, m, p, inc;
        int k;
        d = gz - gyro_bias;
        mag = ((d < 0 ? -d : d) * ms * 65536 + 65500) / 131000;
        if (mag >= deadband && mag != 0) begin
            s = longint'(yaw_q) + (d > 0 ? -longint'(mag) : longint'(mag));
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            yaw_q = 32'(s);
        end
        px = vx;
        py = vy;
        vx = clamp_vel(vx + (ax - ax_bias) * ms);
        vy = clamp_vel(vy + (ay - ay_bias) * ms);
        ux = (vx + px) < 0 ? -(vx + px) : (vx + px);
        uy = (vy + py) < 0 ? -(vy + py) : (vy + py);
        m = ux > uy ? ux : uy;
        k = 0;
        while ((m >> 31) != 0 && k < 16) begin
            m = m >> 1;
            k++;
        end
        ux = ux >> k;
        uy = uy >> k;
        mag = int_root(ux * ux + uy * uy) << k;
        p = mag * ms;
        inc = (p / 15625) * 512 + ((p % 15625) * 512) / 15625;
        if (inc > 64'hFFFFFFFF) inc = 64'hFFFFFFFF;
        inc = inc + 64'(dist_q);
        dist_q = inc > 64'hFFFFFFFF ? 32'hFFFFFFFF : inc[31:0];
    endtask

    // send one item, update the predictor and queue its result
    task automatic send_item(logic [1:0] cmd, logic [15:0] gz, logic [15:0] ax,
                             logic [15:0] ay, logic [15:0] ms);
        result_t r;
        if (!quiet)
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {ms, ay, ax, gz};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (cmd)
            iydi_pkg::CMD_CAL: begin
                if (cal_cnt == 0) begin
                    gyro_acc = 0; ax_acc = 0; ay_acc = 0;
                end
                gyro_acc += longint'($signed(gz));
                ax_acc += longint'($signed(ax));
                ay_acc += longint'($signed(ay));
                cal_cnt++;
                if (cal_cnt >= iydi_pkg::CAL_SAMPLES) begin
                    // signed division truncates toward zero
                    gyro_bias = gyro_acc / iydi_pkg::CAL_SAMPLES;
                    ax_bias = ax_acc / iydi_pkg::CAL_SAMPLES;
                    ay_bias = ay_acc / iydi_pkg::CAL_SAMPLES;
                    cal_done = 1'b1;
                    cal_cnt = 0;
                end
            end
            iydi_pkg::CMD_MOTION: integrate_motion($signed(gz), $signed(ax), $signed(ay), ms);
            iydi_pkg::CMD_RESET_YAW: yaw_q = 0;
            default: begin
                vx = 0; vy = 0;
            end
        endcase
        r.yaw = yaw_q;
        r.distance = dist_q;
        r.calibrated = cal_done;
        pending_results.push_back(r);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_deadband(logic [15:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        deadband = v;
    endtask

    function automatic logic [15:0] rnd16();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 15));
            3: return 16'(-$urandom_range(1, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    // result checker
    always @(posedge aclk) begin
        result_t got, want;
        cycles++;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[64:0];
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.yaw !== want.yaw) begin
                    $display("%0t yaw expected %h actual %h", $time, want.yaw, got.yaw);
                    errors++;
                end
                if (got.distance !== want.distance) begin
                    $display("%0t distance expected %h actual %h", $time, want.distance,
                             got.distance);
                    errors++;
                end
                if (got.calibrated !== want.calibrated) begin
                    $display("%0t calibrated expected %b actual %b", $time,
                             want.calibrated, got.calibrated);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stalls m_tready in random bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && m_tready && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= int'($urandom_range(0, 2));
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic test_uncalibrated_motion();
        send_item(iydi_pkg::CMD_MOTION, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_item(iydi_pkg::CMD_MOTION, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_item(iydi_pkg::CMD_MOTION, 16'd1, 16'd0, 16'd0, 16'd1);
        send_item(iydi_pkg::CMD_MOTION, 16'd100, 16'd5, 16'd5, 16'd0);
        send_item(iydi_pkg::CMD_RESET_YAW, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(iydi_pkg::CMD_RESET_VEL, 16'h0, 16'h0, 16'h0, 16'h0);
    endtask

    // interleaved other commands must not break the run
    task automatic test_calibration(bit with_noise);
        for (int i = 0; i < iydi_pkg::CAL_SAMPLES; i++) begin
            send_item(iydi_pkg::CMD_CAL,
                      $urandom_range(0, 1) ? rnd16() : 16'($urandom_range(0, 40) - 20),
                      16'($urandom), 16'($urandom), 16'($urandom));
            if (with_noise && $urandom_range(0, 9) == 0)
                send_item(2'($urandom_range(1, 3)), rnd16(), rnd16(), rnd16(),
                          16'($urandom_range(0, 50)));
        end
    endtask

    task automatic test_saturation();
        // long strong rotation and acceleration drive yaw and distance to their limits
        for (int i = 0; i < 20; i++)
            send_item(iydi_pkg::CMD_MOTION, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        for (int i = 0; i < 20; i++)
            send_item(iydi_pkg::CMD_MOTION, 16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF);
        send_item(iydi_pkg::CMD_RESET_YAW, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(iydi_pkg::CMD_RESET_VEL, 16'd0, 16'd0, 16'd0, 16'd0);
    endtask

    task automatic test_random(int n);
        int c;
        for (int i = 0; i < n; i++) begin
            c = $urandom_range(0, 19);
            if (c < 14)
                send_item(iydi_pkg::CMD_MOTION, rnd16(), rnd16(), rnd16(),
                          $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                    : 16'($urandom_range(0, 100)));
            else if (c < 16)
                send_item(iydi_pkg::CMD_CAL, rnd16(), rnd16(), rnd16(), 16'($urandom));
            else if (c < 18)
                send_item(iydi_pkg::CMD_RESET_YAW, rnd16(), rnd16(), rnd16(), 16'($urandom));
            else
                send_item(iydi_pkg::CMD_RESET_VEL, rnd16(), rnd16(), rnd16(), 16'($urandom));
        end
    endtask

    initial begin
        deadband = iydi_pkg::DEADBAND_RST;
        cal_cnt = 0;
        gyro_acc = 0; ax_acc = 0; ay_acc = 0;
        gyro_bias = 0; ax_bias = 0; ay_bias = 0;
        yaw_q = 0; vx = 0; vy = 0; dist_q = 0;
        cal_done = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_uncalibrated_motion();
        write_deadband(16'd0);
        test_uncalibrated_motion();
        test_calibration(1'b0);
        test_saturation();
        write_deadband(16'hFFFF);
        test_random(120);
        wait_drained();
        write_deadband(16'($urandom));
        test_calibration(1'b1);
        test_random(100);
        write_deadband(16'd1);
        test_random(150);
        write_deadband(iydi_pkg::DEADBAND_RST);
        quiet = 1'b1;
        test_random(100);

        wait_drained();
        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
